FILE: src/modular_exponentiation_unit_core_macros.svh
// Assertion macros shared by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_UNIT_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MME_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modexp check failed");

// Next-cycle implication, disabled while reset is high.
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modexp check failed");

`endif

FILE: src/mme_pkg.sv
// Shared constants and types of the modular exponentiation unit.
package mme_pkg;

   localparam int MOD_WIDTH_DEF = 31;
   localparam int IN_WIDTH      = 32;
   localparam int OUT_WIDTH     = 31;
   localparam int CSR_WIDTH     = 31;
   localparam int CNT_WIDTH     = $clog2(IN_WIDTH + 1);

   typedef struct packed {
      logic clear;
      logic dbl;
      logic add;
   } acc_cmd_type;

endpackage

FILE: src/modular_exponentiation_unit_core.sv
// A zero exponent is answered from idle with a result of 1 and never raises busy. Otherwise the
// base is first reduced one bit at a time (a double state then an add state per bit), then each
// exponent bit runs one bit-serial square and one bit-serial multiply side by side, one
// multiplier bit at a time, up to the top set exponent bit.
// One transaction at a time; with a nonzero exponent busy is high from acceptance until the result strobe.
// Synchronous reset returns to idle and sets the modulus to 1.
module modular_exponentiation_unit_core #(
   parameter int MOD_WIDTH = mme_pkg::MOD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [mme_pkg::IN_WIDTH-1:0]   req_base,
   input  logic [mme_pkg::IN_WIDTH-1:0]   req_exponent,
   output logic                           rsp_strobe,
   output logic [mme_pkg::OUT_WIDTH-1:0]  rsp_power_mod,
   input  logic                           csr_we,
   input  logic [mme_pkg::CSR_WIDTH-1:0]  csr_wdata
);

   localparam int W  = MOD_WIDTH;
   localparam int IW = mme_pkg::IN_WIDTH;
   localparam int CW = mme_pkg::CNT_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RED_DBL,
      S_RED_ADD,
      S_SETUP,
      S_MUL_DBL,
      S_MUL_ADD,
      S_MUL_END
   } state_type;

   state_type                    state_ff;
   logic [W-1:0]                 modulus_ff;
   logic [IW-1:0]                base_ff;
   logic [IW-1:0]                exp_ff;
   logic [W-1:0]                 acc_ff;
   logic [W-1:0]                 sq_ff;
   logic [W-1:0]                 mbits_ff;
   logic [CW-1:0]                cnt_ff;
   logic                         rsp_strobe_ff;
   logic                         rsp_strobe_in;
   logic [mme_pkg::OUT_WIDTH-1:0] rsp_power_mod_ff;

   mme_pkg::acc_cmd_type cmd_a;
   mme_pkg::acc_cmd_type cmd_b;
   logic [W-1:0]         addend_a;
   logic [W-1:0]         res_a;
   logic [W-1:0]         res_b;
   logic                 accept;
   logic [W-1:0]         acc_next;
   logic [W-1:0]         wdata_low;

   assign accept    = start && (state_ff == S_IDLE);
   assign acc_next  = exp_ff[0] ? res_a : acc_ff;
   assign wdata_low = csr_wdata[W-1:0];
   assign rsp_strobe_in = (accept && (req_exponent == '0)) ||
                          ((state_ff == S_MUL_END) && (exp_ff[IW-1:1] == '0));

   always_comb begin
      cmd_a    = '0;
      cmd_b    = '0;
      addend_a = acc_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd_a.clear = accept;
         end
         S_RED_DBL: begin
            cmd_a.dbl = 1'b1;
         end
         S_RED_ADD: begin
            cmd_a.add = 1'b1;
            addend_a  = W'(base_ff[IW-1]);
         end
         S_SETUP, S_MUL_END: begin
            cmd_a.clear = 1'b1;
            cmd_b.clear = 1'b1;
         end
         S_MUL_DBL: begin
            cmd_a.dbl = 1'b1;
            cmd_b.dbl = 1'b1;
         end
         S_MUL_ADD: begin
            cmd_a.add = mbits_ff[W-1];
            cmd_b.add = mbits_ff[W-1];
         end
         default: begin
            cmd_a = '0;
         end
      endcase
   end

   mme_modacc #(.W(W)) u_acc_mul (
      .clock   (clock),
      .cmd     (cmd_a),
      .modulus (modulus_ff),
      .addend  (addend_a),
      .result  (res_a)
   );

   mme_modacc #(.W(W)) u_sq_mul (
      .clock   (clock),
      .cmd     (cmd_b),
      .modulus (modulus_ff),
      .addend  (sq_ff),
      .result  (res_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         modulus_ff    <= W'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            modulus_ff <= (wdata_low == '0) ? W'(1) : wdata_low;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_exponent == '0) begin
                     rsp_power_mod_ff <= mme_pkg::OUT_WIDTH'(1);
                  end else begin
                     base_ff  <= req_base;
                     exp_ff   <= req_exponent;
                     acc_ff   <= (modulus_ff == W'(1)) ? '0 : W'(1);
                     cnt_ff   <= CW'(IW);
                     state_ff <= S_RED_DBL;
                  end
               end
            end
            S_RED_DBL: begin
               state_ff <= S_RED_ADD;
            end
            S_RED_ADD: begin
               base_ff <= {base_ff[IW-2:0], 1'b0};
               cnt_ff  <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_ff <= S_SETUP;
               end else begin
                  state_ff <= S_RED_DBL;
               end
            end
            S_SETUP: begin
               sq_ff    <= res_a;
               mbits_ff <= res_a;
               cnt_ff   <= CW'(W);
               state_ff <= S_MUL_DBL;
            end
            S_MUL_DBL: begin
               state_ff <= S_MUL_ADD;
            end
            S_MUL_ADD: begin
               mbits_ff <= {mbits_ff[W-2:0], 1'b0};
               cnt_ff   <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_ff <= S_MUL_END;
               end else begin
                  state_ff <= S_MUL_DBL;
               end
            end
            S_MUL_END: begin
               acc_ff   <= acc_next;
               sq_ff    <= res_b;
               mbits_ff <= res_b;
               exp_ff   <= {1'b0, exp_ff[IW-1:1]};
               cnt_ff   <= CW'(W);
               if (exp_ff[IW-1:1] == '0) begin
                  rsp_power_mod_ff <= mme_pkg::OUT_WIDTH'(acc_next);
                  state_ff         <= S_IDLE;
               end else begin
                  state_ff <= S_MUL_DBL;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_power_mod = rsp_power_mod_ff;

endmodule

FILE: src/mme_modacc.sv
// Serial modular accumulator: clears, doubles or adds an operand, reducing each step.
module mme_modacc #(
   parameter int W = mme_pkg::MOD_WIDTH_DEF
) (
   input  logic                 clock,
   input  mme_pkg::acc_cmd_type cmd,
   input  logic [W-1:0]         modulus,
   input  logic [W-1:0]         addend,
   output logic [W-1:0]         result
);

   logic [W-1:0] r_ff;
   logic [W-1:0] r_in;
   logic [W:0]   sum;
   logic [W:0]   diff;

   always_comb begin
      if (cmd.dbl) begin
         sum = {r_ff, 1'b0};
      end else begin
         sum = {1'b0, r_ff} + {1'b0, addend};
      end
      diff = sum - {1'b0, modulus};
      r_in = r_ff;
      if (cmd.clear) begin
         r_in = '0;
      end else if (cmd.dbl || cmd.add) begin
         r_in = (sum >= {1'b0, modulus}) ? diff[W-1:0] : sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   assign result = r_ff;

endmodule

FILE: src/mme_checker.sv
// Port-level checker for the modular exponentiation unit, bound to the top level.
`include "modular_exponentiation_unit_core_macros.svh"

module mme_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [mme_pkg::IN_WIDTH-1:0]  req_exponent,
   input logic                          rsp_strobe,
   input logic [mme_pkg::OUT_WIDTH-1:0] rsp_power_mod
);

   `MME_ASSERT_NEXT(a_zero_exp_gives_one, clock, reset, start && !busy && (req_exponent == '0), rsp_strobe && (rsp_power_mod == mme_pkg::OUT_WIDTH'(1)))
   `MME_ASSERT_NEXT(a_work_sets_busy, clock, reset, start && !busy && (req_exponent != '0), busy)
   `MME_ASSERT_IMPLY(a_done_has_result, clock, reset, $fell(busy), rsp_strobe)

endmodule

bind modular_exponentiation_unit_core mme_checker u_mme_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_exponent  (req_exponent),
   .rsp_strobe    (rsp_strobe),
   .rsp_power_mod (rsp_power_mod)
);
